/* src/rtch_pkg.sv */
// Shared types, codes and the product schedule of the ray/triangle closest-hit core.
// Used by rtch_ctrl, rtch_datapath and ray_triangle_closest_hit_core.
package rtch_pkg;

  localparam int unsigned NumSteps = 24;
  localparam int unsigned DivBits  = 31;
  localparam logic [30:0] DistNone = 31'h7FFF_FFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIRECTION_X = 3'd3,
    REG_DIRECTION_Y = 3'd4,
    REG_DIRECTION_Z = 3'd5,
    REG_TOLERANCE   = 3'd6
  } reg_index_t;

  // operand vector slots
  localparam logic [4:0] OpD0 = 5'd0;
  localparam logic [4:0] OpD1 = 5'd1;
  localparam logic [4:0] OpD2 = 5'd2;
  localparam logic [4:0] OpE10 = 5'd3;
  localparam logic [4:0] OpE11 = 5'd4;
  localparam logic [4:0] OpE12 = 5'd5;
  localparam logic [4:0] OpE20 = 5'd6;
  localparam logic [4:0] OpE21 = 5'd7;
  localparam logic [4:0] OpE22 = 5'd8;
  localparam logic [4:0] OpS0 = 5'd9;
  localparam logic [4:0] OpS1 = 5'd10;
  localparam logic [4:0] OpS2 = 5'd11;
  localparam logic [4:0] OpH0 = 5'd12;
  localparam logic [4:0] OpH1 = 5'd13;
  localparam logic [4:0] OpH2 = 5'd14;
  localparam logic [4:0] OpQ0 = 5'd15;
  localparam logic [4:0] OpQ1 = 5'd16;
  localparam logic [4:0] OpQ2 = 5'd17;

  // where a finished sum goes
  typedef enum logic [3:0] {
    DST_NONE, DST_H0, DST_H1, DST_H2, DST_A,
    DST_Q0, DST_Q1, DST_Q2, DST_NU, DST_NV, DST_NT
  } dst_t;

  typedef struct packed {
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic       neg;
    dst_t       dst;
  } step_info_t;

  typedef enum logic [1:0] {
    DIV_T, DIV_U, DIV_V
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_NORM, ST_TEST, ST_DIV_LOAD, ST_DIV_RUN, ST_FIN
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [4:0] mul_step;
    logic       acc_en;
    logic [4:0] acc_step;
    logic       norm;
    logic       div_load;
    logic       div_iter;
    logic       div_last;
    div_sel_t   div_sel;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic pass;
  } status_t;

  // product schedule: h = d x e2, a = e1.h, q = s x e1, nu = s.h, nv = d.q, nt = e2.q
  function automatic step_info_t step_info(input logic [4:0] step);
    step_info_t r;
    r = '{a_sel: OpD0, b_sel: OpD0, neg: 1'b0, dst: DST_NONE};
    unique case (step)
      5'd0:  r = '{OpD1,  OpE22, 1'b0, DST_NONE};
      5'd1:  r = '{OpD2,  OpE21, 1'b1, DST_H0};
      5'd2:  r = '{OpD2,  OpE20, 1'b0, DST_NONE};
      5'd3:  r = '{OpD0,  OpE22, 1'b1, DST_H1};
      5'd4:  r = '{OpD0,  OpE21, 1'b0, DST_NONE};
      5'd5:  r = '{OpD1,  OpE20, 1'b1, DST_H2};
      5'd6:  r = '{OpE10, OpH0,  1'b0, DST_NONE};
      5'd7:  r = '{OpE11, OpH1,  1'b0, DST_NONE};
      5'd8:  r = '{OpE12, OpH2,  1'b0, DST_A};
      5'd9:  r = '{OpS1,  OpE12, 1'b0, DST_NONE};
      5'd10: r = '{OpS2,  OpE11, 1'b1, DST_Q0};
      5'd11: r = '{OpS2,  OpE10, 1'b0, DST_NONE};
      5'd12: r = '{OpS0,  OpE12, 1'b1, DST_Q1};
      5'd13: r = '{OpS0,  OpE11, 1'b0, DST_NONE};
      5'd14: r = '{OpS1,  OpE10, 1'b1, DST_Q2};
      5'd15: r = '{OpS0,  OpH0,  1'b0, DST_NONE};
      5'd16: r = '{OpS1,  OpH1,  1'b0, DST_NONE};
      5'd17: r = '{OpS2,  OpH2,  1'b0, DST_NU};
      5'd18: r = '{OpD0,  OpQ0,  1'b0, DST_NONE};
      5'd19: r = '{OpD1,  OpQ1,  1'b0, DST_NONE};
      5'd20: r = '{OpD2,  OpQ2,  1'b0, DST_NV};
      5'd21: r = '{OpE20, OpQ0,  1'b0, DST_NONE};
      5'd22: r = '{OpE21, OpQ1,  1'b0, DST_NONE};
      5'd23: r = '{OpE22, OpQ2,  1'b0, DST_NT};
      default: r = '{OpD0, OpD0, 1'b0, DST_NONE};
    endcase
    return r;
  endfunction

endpackage

/* src/rtch_ctrl.sv */
// Sequencer of the ray/triangle closest-hit core: product schedule, divisions, result beat.
// Depends on rtch_pkg; drives rtch_datapath through rtch_pkg::cmd_t.
module rtch_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rtch_pkg::status_t status,
  output rtch_pkg::cmd_t   cmd
);

  rtch_pkg::state_t   state, state_next;
  logic [4:0]         cnt, cnt_next;
  rtch_pkg::div_sel_t sel, sel_next;
  logic               in_fire;
  logic               slot_free;

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rtch_pkg::ST_IDLE:     if (in_valid) state_next = rtch_pkg::ST_MUL;
      rtch_pkg::ST_MUL:      if (cnt == 5'(rtch_pkg::NumSteps)) state_next = rtch_pkg::ST_NORM;
      rtch_pkg::ST_NORM:     state_next = rtch_pkg::ST_TEST;
      rtch_pkg::ST_TEST:     state_next = status.pass ? rtch_pkg::ST_DIV_LOAD : rtch_pkg::ST_FIN;
      rtch_pkg::ST_DIV_LOAD: state_next = rtch_pkg::ST_DIV_RUN;
      rtch_pkg::ST_DIV_RUN: begin
        if (cnt == 5'(rtch_pkg::DivBits - 1)) begin
          state_next = (sel == rtch_pkg::DIV_V) ? rtch_pkg::ST_FIN : rtch_pkg::ST_DIV_LOAD;
        end
      end
      rtch_pkg::ST_FIN:      if (slot_free) state_next = rtch_pkg::ST_IDLE;
      default:               state_next = rtch_pkg::ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    cnt_next = cnt;
    sel_next = sel;
    unique case (state)
      rtch_pkg::ST_IDLE:     cnt_next = '0;
      rtch_pkg::ST_MUL:      cnt_next = cnt + 5'd1;
      rtch_pkg::ST_TEST:     sel_next = rtch_pkg::DIV_T;
      rtch_pkg::ST_DIV_LOAD: cnt_next = '0;
      rtch_pkg::ST_DIV_RUN: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(rtch_pkg::DivBits - 1)) begin
          sel_next = (sel == rtch_pkg::DIV_T) ? rtch_pkg::DIV_U : rtch_pkg::DIV_V;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.div_sel  = sel;
    in_ready     = 1'b0;
    unique case (state)
      rtch_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rtch_pkg::ST_MUL: begin
        cmd.mul_en   = (cnt < 5'(rtch_pkg::NumSteps));
        cmd.mul_step = cnt;
        cmd.acc_en   = (cnt != 5'd0);
        cmd.acc_step = cnt - 5'd1;
      end
      rtch_pkg::ST_NORM:     cmd.norm = 1'b1;
      rtch_pkg::ST_DIV_LOAD: cmd.div_load = 1'b1;
      rtch_pkg::ST_DIV_RUN: begin
        cmd.div_iter = 1'b1;
        cmd.div_last = (cnt == 5'(rtch_pkg::DivBits - 1));
      end
      rtch_pkg::ST_FIN:      cmd.finish = slot_free;
      default: ;
    endcase
  end

  // state registers and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rtch_pkg::ST_IDLE;
      cnt       <= '0;
      sel       <= rtch_pkg::DIV_T;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("rtch_ctrl: ready right after an accepted beat");

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> slot_free)
    else $error("rtch_ctrl: result loaded over a pending beat");

  a_div_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == rtch_pkg::ST_DIV_RUN |-> cnt < 5'(rtch_pkg::DivBits))
    else $error("rtch_ctrl: division count out of range");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("rtch_ctrl: result dropped while stalled");

endmodule

/* src/rtch_datapath.sv */
// Datapath of the ray/triangle closest-hit core: ray registers, shared multiplier,
// accumulator, bit-serial divider, closest record and result registers. Uses rtch_pkg.
module rtch_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rtch_pkg::cmd_t      cmd,
  output rtch_pkg::status_t   status,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [31:0]  vertex0_x,
  input  logic signed [31:0]  vertex0_y,
  input  logic signed [31:0]  vertex0_z,
  input  logic signed [31:0]  vertex1_x,
  input  logic signed [31:0]  vertex1_y,
  input  logic signed [31:0]  vertex1_z,
  input  logic signed [31:0]  vertex2_x,
  input  logic signed [31:0]  vertex2_y,
  input  logic signed [31:0]  vertex2_z,
  input  logic [15:0]         triangle_id,
  input  logic                first_of_ray,
  output logic                hit,
  output logic [30:0]         distance,
  output logic [16:0]         bary_u,
  output logic [16:0]         bary_v,
  output logic [30:0]         closest_distance,
  output logic [15:0]         closest_id,
  output logic                any_hit
);

  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
    logic signed [32:0] d;
    d = 33'(x) - 33'(y);
    if (d > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (d < -33'sh0_8000_0000) return 32'sh8000_0000;
    return d[31:0];
  endfunction

  function automatic logic signed [31:0] sat_acc(input logic signed [49:0] x);
    if (x > 50'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -50'sh0_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // ray and tolerance
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic [15:0]        tol;

  // operands and results
  logic signed [31:0] e1 [3];
  logic signed [31:0] e2 [3];
  logic signed [31:0] sv [3];
  logic signed [31:0] hv [3];
  logic signed [31:0] qv [3];
  logic signed [49:0] a_sum, nu_sum, nv_sum, nt_sum;
  logic signed [49:0] acc;
  logic signed [63:0] prod;
  logic [15:0]        cur_id;

  // divider
  logic [49:0] rem;
  logic [30:0] dbits;
  logic [29:0] quo;
  logic        dsat;
  logic [30:0] t_q, u_q, v_q;

  // closest record
  logic [30:0] best_distance;
  logic [15:0] best_id;
  logic        found_flag;

  rtch_pkg::step_info_t mstep, astep;
  logic signed [31:0]   opa, opb;
  logic signed [47:0]   term;
  logic signed [49:0]   sum;
  logic signed [50:0]   nuv;
  logic [49:0]          dnum;
  logic [50:0]          rtry;
  logic                 qbit;
  logic                 hit_now;

  function automatic logic signed [31:0] pick(input logic [4:0] s,
                                              input logic signed [31:0] d0,
                                              input logic signed [31:0] d1,
                                              input logic signed [31:0] d2,
                                              input logic signed [31:0] a0,
                                              input logic signed [31:0] a1,
                                              input logic signed [31:0] a2,
                                              input logic signed [31:0] b0,
                                              input logic signed [31:0] b1,
                                              input logic signed [31:0] b2,
                                              input logic signed [31:0] c0,
                                              input logic signed [31:0] c1,
                                              input logic signed [31:0] c2,
                                              input logic signed [31:0] h0,
                                              input logic signed [31:0] h1,
                                              input logic signed [31:0] h2,
                                              input logic signed [31:0] q0,
                                              input logic signed [31:0] q1,
                                              input logic signed [31:0] q2);
    logic signed [31:0] r;
    unique case (s)
      rtch_pkg::OpD0:  r = d0;
      rtch_pkg::OpD1:  r = d1;
      rtch_pkg::OpD2:  r = d2;
      rtch_pkg::OpE10: r = a0;
      rtch_pkg::OpE11: r = a1;
      rtch_pkg::OpE12: r = a2;
      rtch_pkg::OpE20: r = b0;
      rtch_pkg::OpE21: r = b1;
      rtch_pkg::OpE22: r = b2;
      rtch_pkg::OpS0:  r = c0;
      rtch_pkg::OpS1:  r = c1;
      rtch_pkg::OpS2:  r = c2;
      rtch_pkg::OpH0:  r = h0;
      rtch_pkg::OpH1:  r = h1;
      rtch_pkg::OpH2:  r = h2;
      rtch_pkg::OpQ0:  r = q0;
      rtch_pkg::OpQ1:  r = q1;
      rtch_pkg::OpQ2:  r = q2;
      default:         r = '0;
    endcase
    return r;
  endfunction

  // select multiplier operands for this step
  always_comb begin
    mstep = rtch_pkg::step_info(cmd.mul_step);
    astep = rtch_pkg::step_info(cmd.acc_step);
    opa = pick(mstep.a_sel, dir[0], dir[1], dir[2], e1[0], e1[1], e1[2],
               e2[0], e2[1], e2[2], sv[0], sv[1], sv[2],
               hv[0], hv[1], hv[2], qv[0], qv[1], qv[2]);
    opb = pick(mstep.b_sel, dir[0], dir[1], dir[2], e1[0], e1[1], e1[2],
               e2[0], e2[1], e2[2], sv[0], sv[1], sv[2],
               hv[0], hv[1], hv[2], qv[0], qv[1], qv[2]);
    // arithmetic shift floors the Q32.32 product to Q32.16
    term = prod[63:16];
    sum  = astep.neg ? (acc - 50'(term)) : (acc + 50'(term));
  end

  // hit tests on the normalized sums
  always_comb begin
    nuv = 51'(nu_sum) + 51'(nv_sum);
    status.pass = (a_sum != '0) && (a_sum >= $signed({34'd0, tol})) &&
                  (nu_sum >= 0) && (nu_sum <= a_sum) && (nv_sum >= 0) &&
                  (nuv <= 51'(a_sum)) && (nt_sum > 0);
  end

  // divider step
  always_comb begin
    unique case (cmd.div_sel)
      rtch_pkg::DIV_T: dnum = nt_sum;
      rtch_pkg::DIV_U: dnum = nu_sum;
      rtch_pkg::DIV_V: dnum = nv_sum;
      default:         dnum = nt_sum;
    endcase
    rtry = {rem, dbits[30]};
    qbit = (rtry >= {1'b0, a_sum});
    hit_now = status.pass && (t_q > {15'd0, tol}) && (t_q < best_distance);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= 32'sd65536;
      tol    <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtch_pkg::REG_ORIGIN_X:    org[0] <= cfg_data;
        rtch_pkg::REG_ORIGIN_Y:    org[1] <= cfg_data;
        rtch_pkg::REG_ORIGIN_Z:    org[2] <= cfg_data;
        rtch_pkg::REG_DIRECTION_X: dir[0] <= cfg_data;
        rtch_pkg::REG_DIRECTION_Y: dir[1] <= cfg_data;
        rtch_pkg::REG_DIRECTION_Z: dir[2] <= cfg_data;
        rtch_pkg::REG_TOLERANCE:   tol    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // edges, products, sums, divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e1[0]  <= sat_diff(vertex1_x, vertex0_x);
      e1[1]  <= sat_diff(vertex1_y, vertex0_y);
      e1[2]  <= sat_diff(vertex1_z, vertex0_z);
      e2[0]  <= sat_diff(vertex2_x, vertex0_x);
      e2[1]  <= sat_diff(vertex2_y, vertex0_y);
      e2[2]  <= sat_diff(vertex2_z, vertex0_z);
      sv[0]  <= sat_diff(org[0], vertex0_x);
      sv[1]  <= sat_diff(org[1], vertex0_y);
      sv[2]  <= sat_diff(org[2], vertex0_z);
      cur_id <= triangle_id;
      acc    <= '0;
    end
    if (cmd.mul_en) begin
      prod <= opa * opb;
    end
    if (cmd.acc_en) begin
      acc <= (astep.dst == rtch_pkg::DST_NONE) ? sum : '0;
      unique case (astep.dst)
        rtch_pkg::DST_H0: hv[0]  <= sat_acc(sum);
        rtch_pkg::DST_H1: hv[1]  <= sat_acc(sum);
        rtch_pkg::DST_H2: hv[2]  <= sat_acc(sum);
        rtch_pkg::DST_A:  a_sum  <= sum;
        rtch_pkg::DST_Q0: qv[0]  <= sat_acc(sum);
        rtch_pkg::DST_Q1: qv[1]  <= sat_acc(sum);
        rtch_pkg::DST_Q2: qv[2]  <= sat_acc(sum);
        rtch_pkg::DST_NU: nu_sum <= sum;
        rtch_pkg::DST_NV: nv_sum <= sum;
        rtch_pkg::DST_NT: nt_sum <= sum;
        default: ;
      endcase
    end
    // make the divisor positive
    if (cmd.norm && a_sum < 0) begin
      a_sum  <= -a_sum;
      nu_sum <= -nu_sum;
      nv_sum <= -nv_sum;
      nt_sum <= -nt_sum;
    end
    if (cmd.div_load) begin
      rem   <= {15'd0, dnum[49:15]};
      dsat  <= ({15'd0, dnum[49:15]} >= a_sum[49:0]);
      dbits <= {dnum[14:0], 16'd0};
      quo   <= '0;
    end
    if (cmd.div_iter) begin
      rem   <= qbit ? 50'(rtry - {1'b0, a_sum}) : rtry[49:0];
      dbits <= {dbits[29:0], 1'b0};
      quo   <= {quo[28:0], qbit};
      if (cmd.div_last) begin
        unique case (cmd.div_sel)
          rtch_pkg::DIV_T: t_q <= dsat ? rtch_pkg::DistNone : {quo, qbit};
          rtch_pkg::DIV_U: u_q <= {quo, qbit};
          rtch_pkg::DIV_V: v_q <= {quo, qbit};
          default: ;
        endcase
      end
    end
  end

  // closest record
  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= rtch_pkg::DistNone;
      best_id       <= '0;
      found_flag    <= 1'b0;
    end else if (cmd.load && first_of_ray) begin
      best_distance <= rtch_pkg::DistNone;
      best_id       <= '0;
      found_flag    <= 1'b0;
    end else if (cmd.finish && hit_now) begin
      best_distance <= t_q;
      best_id       <= cur_id;
      found_flag    <= 1'b1;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit              <= hit_now;
      distance         <= hit_now ? t_q : '0;
      bary_u           <= hit_now ? u_q[16:0] : '0;
      bary_v           <= hit_now ? v_q[16:0] : '0;
      closest_distance <= hit_now ? t_q : best_distance;
      closest_id       <= hit_now ? cur_id : best_id;
      any_hit          <= hit_now || found_flag;
    end
  end

endmodule

/* src/ray_triangle_closest_hit_core.sv */
// Top level of the ray/triangle closest-hit core (Moller-Trumbore, signed Q16.16).
// Depends on rtch_pkg, rtch_ctrl and rtch_datapath.
//
// Usage: write the ray origin, direction and tolerance on the cfg channel
// (index 0..6, cfg_ready is always high, unknown indexes are ignored) while
// the core is idle, then stream triangles on the in channel. Each input beat
// yields exactly one output beat with this triangle's hit, distance and
// barycentrics plus the closest record of the ray so far. first_of_ray
// clears the record before the triangle is tested.
// Sequence: accept, then the products on the shared 32x32 multiplier (24 products
// and one trailing accumulate), the normalize and test states, then when the triangle
// passes the hit tests three restoring divisions (t, u, v) through one
// bit-serial divider, then the load of the result register. Only one triangle
// is in flight at a time: in_ready is high only while the core is idle.
// The result register decouples the channels: a new triangle is accepted
// while the previous result still waits; a stalled receiver holds the core
// in its final state until the register frees.
// Reset (synchronous, rst high) restores the register defaults, clears the
// closest record and drops out_valid.
module ray_triangle_closest_hit_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vertex0_x,
  input  logic signed [31:0] vertex0_y,
  input  logic signed [31:0] vertex0_z,
  input  logic signed [31:0] vertex1_x,
  input  logic signed [31:0] vertex1_y,
  input  logic signed [31:0] vertex1_z,
  input  logic signed [31:0] vertex2_x,
  input  logic signed [31:0] vertex2_y,
  input  logic signed [31:0] vertex2_z,
  input  logic [15:0]        triangle_id,
  input  logic               first_of_ray,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [30:0]        distance,
  output logic [16:0]        bary_u,
  output logic [16:0]        bary_v,
  output logic [30:0]        closest_distance,
  output logic [15:0]        closest_id,
  output logic               any_hit
);

  rtch_pkg::cmd_t    cmd;
  rtch_pkg::status_t status;

  assign cfg_ready = 1'b1;

  rtch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rtch_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .vertex0_x        (vertex0_x),
    .vertex0_y        (vertex0_y),
    .vertex0_z        (vertex0_z),
    .vertex1_x        (vertex1_x),
    .vertex1_y        (vertex1_y),
    .vertex1_z        (vertex1_z),
    .vertex2_x        (vertex2_x),
    .vertex2_y        (vertex2_y),
    .vertex2_z        (vertex2_z),
    .triangle_id      (triangle_id),
    .first_of_ray     (first_of_ray),
    .hit              (hit),
    .distance         (distance),
    .bary_u           (bary_u),
    .bary_v           (bary_v),
    .closest_distance (closest_distance),
    .closest_id       (closest_id),
    .any_hit          (any_hit)
  );

endmodule

/* tb/sv/ray_triangle_closest_hit_checker.sv */
`timescale 1ns / 100ps
// Checker for the ray/triangle closest-hit core: tracks register writes, predicts
// each result beat from the triangle beats and compares. Depends on rtch_pkg.
module ray_triangle_closest_hit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] vertex0_x,
  input  logic signed [31:0] vertex0_y,
  input  logic signed [31:0] vertex0_z,
  input  logic signed [31:0] vertex1_x,
  input  logic signed [31:0] vertex1_y,
  input  logic signed [31:0] vertex1_z,
  input  logic signed [31:0] vertex2_x,
  input  logic signed [31:0] vertex2_y,
  input  logic signed [31:0] vertex2_z,
  input  logic [15:0]        triangle_id,
  input  logic               first_of_ray,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               hit,
  input  logic [30:0]        distance,
  input  logic [16:0]        bary_u,
  input  logic [16:0]        bary_v,
  input  logic [30:0]        closest_distance,
  input  logic [15:0]        closest_id,
  input  logic               any_hit,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic        hit;
    logic [30:0] distance;
    logic [16:0] bary_u;
    logic [16:0] bary_v;
    logic [30:0] closest_distance;
    logic [15:0] closest_id;
    logic        any_hit;
  } hit_record_t;

  hit_record_t hit_queue[$];

  // ray registers and the closest record of the current ray
  longint      ray_org[3];
  longint      ray_dir[3];
  logic [15:0] tol;
  logic [30:0] best_dist;
  logic [15:0] best_tri;
  logic        found;

  assign pending = hit_queue.size();

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // full-precision product, shifted right 16 rounding toward minus infinity
  function automatic longint fx_mul(longint x, longint y);
    longint p;
    p = x * y;
    return p >>> 16;
  endfunction

  function automatic longint fx_dot(longint x[3], longint y[3]);
    return fx_mul(x[0], y[0]) + fx_mul(x[1], y[1]) + fx_mul(x[2], y[2]);
  endfunction

  function automatic void fx_cross(input longint x[3], input longint y[3],
                                   output longint r[3]);
    r[0] = sat32(fx_mul(x[1], y[2]) - fx_mul(x[2], y[1]));
    r[1] = sat32(fx_mul(x[2], y[0]) - fx_mul(x[0], y[2]));
    r[2] = sat32(fx_mul(x[0], y[1]) - fx_mul(x[1], y[0]));
  endfunction

  // unsigned Q15.16 quotient by restoring division; saturates when the integer part overflows
  function automatic logic [30:0] fx_quotient(longint unsigned num, longint unsigned den);
    longint unsigned whole, rem, frac;
    whole = num / den;
    rem   = num % den;
    frac  = 0;
    if (whole >= 32768) return rtch_pkg::DistNone;
    for (int i = 0; i < 16; i++) begin
      rem  = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem  = rem - den;
        frac = frac | 1;
      end
    end
    return 31'((whole << 16) | frac);
  endfunction

  // run the intersection test for one triangle and update the closest record
  function automatic hit_record_t closest_hit_predict(longint vtx[9], logic [15:0] id,
                                                      logic clear);
    hit_record_t r;
    longint e1[3], e2[3], s[3], h[3], q[3];
    longint a, nu, nv, nt, tl;
    logic [30:0] t;
    r.hit = 0; r.distance = 0; r.bary_u = 0; r.bary_v = 0;
    if (clear) begin
      best_dist = rtch_pkg::DistNone;
      best_tri  = 0;
      found     = 0;
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] = sat32(vtx[3 + i] - vtx[i]);
      e2[i] = sat32(vtx[6 + i] - vtx[i]);
      s[i]  = sat32(ray_org[i] - vtx[i]);
    end
    tl = longint'(tol);
    fx_cross(ray_dir, e2, h);
    a = fx_dot(e1, h);
    if (a != 0 && !(a > -tl && a < tl)) begin
      fx_cross(s, e1, q);
      nu = fx_dot(s, h);
      nv = fx_dot(ray_dir, q);
      nt = fx_dot(e2, q);
      if (a < 0) begin
        a = -a; nu = -nu; nv = -nv; nt = -nt;
      end
      if (nu >= 0 && nu <= a && nv >= 0 && nu + nv <= a && nt > 0) begin
        t = fx_quotient(nt, a);
        if (longint'(t) > tl && t < best_dist) begin
          r.hit      = 1;
          r.distance = t;
          r.bary_u   = 17'(fx_quotient(nu, a));
          r.bary_v   = 17'(fx_quotient(nv, a));
          best_dist  = t;
          best_tri   = id;
          found      = 1;
        end
      end
    end
    r.closest_distance = best_dist;
    r.closest_id       = best_tri;
    r.any_hit          = found;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    hit_record_t want;
    hit_record_t fresh;
    longint vtx[9];
    if (rst) begin
      hit_queue.delete();
      ray_org   = '{0, 0, 0};
      ray_dir   = '{0, 0, 65536};
      tol       = 16'd1;
      best_dist = rtch_pkg::DistNone;
      best_tri  = 0;
      found     = 0;
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rtch_pkg::REG_ORIGIN_X:    ray_org[0] = longint'(signed'(cfg_data));
          rtch_pkg::REG_ORIGIN_Y:    ray_org[1] = longint'(signed'(cfg_data));
          rtch_pkg::REG_ORIGIN_Z:    ray_org[2] = longint'(signed'(cfg_data));
          rtch_pkg::REG_DIRECTION_X: ray_dir[0] = longint'(signed'(cfg_data));
          rtch_pkg::REG_DIRECTION_Y: ray_dir[1] = longint'(signed'(cfg_data));
          rtch_pkg::REG_DIRECTION_Z: ray_dir[2] = longint'(signed'(cfg_data));
          rtch_pkg::REG_TOLERANCE:   tol = cfg_data[15:0];
          default: ;
        endcase
      end
      // compare a result beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (hit_queue.size() == 0) begin
          report_mismatch("result beat with no triangle outstanding", 1, 0);
        end else begin
          want = hit_queue.pop_front();
          if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
          if (distance !== want.distance)
            report_mismatch("distance", distance, want.distance);
          if (bary_u !== want.bary_u) report_mismatch("bary_u", bary_u, want.bary_u);
          if (bary_v !== want.bary_v) report_mismatch("bary_v", bary_v, want.bary_v);
          if (closest_distance !== want.closest_distance)
            report_mismatch("closest_distance", closest_distance, want.closest_distance);
          if (closest_id !== want.closest_id)
            report_mismatch("closest_id", closest_id, want.closest_id);
          if (any_hit !== want.any_hit) report_mismatch("any_hit", any_hit, want.any_hit);
        end
      end
      // predict from each triangle beat
      if (in_valid && in_ready) begin
        vtx = '{vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
                vertex2_x, vertex2_y, vertex2_z};
        fresh = closest_hit_predict(vtx, triangle_id, first_of_ray);
        hit_queue.insert(hit_queue.size(), fresh);
      end
    end
  end

endmodule

/* tb/sv/ray_triangle_closest_hit_core_test.sv */
`timescale 1ns / 100ps
// Top of the ray/triangle closest-hit core testbench: clock, reset, ray setup and
// triangle stimulus, verdict. Depends on rtch_pkg, the core and ray_triangle_closest_hit_checker.
module ray_triangle_closest_hit_core_test;

  localparam int          StallLimit = 5000;
  localparam int          NumRandom  = 1430;
  localparam logic [2:0]  RegUnused  = 3'd7;
  localparam longint      One        = 65536;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = rtch_pkg::REG_ORIGIN_X;
  logic [31:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [31:0] vertex0_x = 0, vertex0_y = 0, vertex0_z = 0;
  logic signed [31:0] vertex1_x = 0, vertex1_y = 0, vertex1_z = 0;
  logic signed [31:0] vertex2_x = 0, vertex2_y = 0, vertex2_z = 0;
  logic [15:0]        triangle_id = 0;
  logic               first_of_ray = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic               hit;
  logic [30:0]        distance;
  logic [16:0]        bary_u;
  logic [16:0]        bary_v;
  logic [30:0]        closest_distance;
  logic [15:0]        closest_id;
  logic               any_hit;
  int                 fail_count;
  int                 pending;

  int                 tx_idle_pct = 18;
  int                 rx_idle_pct = 58;
  int                 stall_cycles = 0;
  longint             cur_org[3] = '{0, 0, 0};
  longint             cur_dir[3] = '{0, 0, 65536};

  always #6 clk = ~clk;

  ray_triangle_closest_hit_core i_dut (.*);

  ray_triangle_closest_hit_checker i_checker (.*);

  // receiver backpressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // end the run when no channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return 32'(v);
  endfunction

  function automatic logic [31:0] rand_signed(int unsigned span);
    return 32'($signed({1'b0, $urandom_range(2 * span)}) - $signed({1'b0, span}));
  endfunction

  // hold valid until the beat is taken; leave it high for the next one
  task automatic send_triangle(logic [31:0] v[9], logic [15:0] id, logic clear);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    {vertex0_x, vertex0_y, vertex0_z} <= {v[0], v[1], v[2]};
    {vertex1_x, vertex1_y, vertex1_z} <= {v[3], v[4], v[5]};
    {vertex2_x, vertex2_y, vertex2_z} <= {v[6], v[7], v[8]};
    triangle_id  <= id;
    first_of_ray <= clear;
    in_valid     <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and wait until every outstanding result has come back
  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= rtch_pkg::REG_ORIGIN_Z) cur_org[idx] = longint'(signed'(data));
    else if (idx <= rtch_pkg::REG_DIRECTION_Z) cur_dir[idx - 3] = longint'(signed'(data));
  endtask

  task automatic set_ray(logic [31:0] o[3], logic [31:0] d[3], logic [15:0] tl);
    write_reg(rtch_pkg::REG_ORIGIN_X, o[0]);
    write_reg(rtch_pkg::REG_ORIGIN_Y, o[1]);
    write_reg(rtch_pkg::REG_ORIGIN_Z, o[2]);
    write_reg(rtch_pkg::REG_DIRECTION_X, d[0]);
    write_reg(rtch_pkg::REG_DIRECTION_Y, d[1]);
    write_reg(rtch_pkg::REG_DIRECTION_Z, d[2]);
    write_reg(rtch_pkg::REG_TOLERANCE, {16'd0, tl});
    cfg_valid <= 0;
  endtask

  // axis-aligned triangle in the plane z = zpos, spanning [x0, x0+w] x [y0, y0+w]
  task automatic send_flat(longint x0, longint y0, longint zpos, longint w,
                           logic [15:0] id, logic clear);
    logic [31:0] v[9];
    v = '{clip32(x0), clip32(y0), clip32(zpos), clip32(x0 + w), clip32(y0), clip32(zpos),
          clip32(x0), clip32(y0 + w), clip32(zpos)};
    send_triangle(v, id, clear);
  endtask

  // triangle placed around a point on the ray, mostly containing it
  task automatic send_random_triangle;
    logic [31:0] v[9];
    longint e1[3], e2[3], pt[3], tpos, al, be, v0;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 75) begin
      tpos = $urandom_range(1 << 19);
      al = (kind < 64) ? $urandom_range(32767) : $urandom_range(80000);
      be = (kind < 64) ? $urandom_range(32767) : $urandom_range(80000);
      for (int i = 0; i < 3; i++) begin
        pt[i] = cur_org[i] + ((cur_dir[i] * tpos) >>> 16);
        e1[i] = longint'(signed'(rand_signed(1 << 18)));
        e2[i] = longint'(signed'(rand_signed(1 << 18)));
        v0 = pt[i] - ((e1[i] * al) >>> 16) - ((e2[i] * be) >>> 16);
        v[i]     = clip32(v0);
        v[3 + i] = clip32(v0 + e1[i]);
        v[6 + i] = clip32(v0 + e2[i]);
      end
    end else if (kind < 90) begin
      foreach (v[i]) v[i] = rand_signed(1 << 20);
    end else begin
      foreach (v[i]) v[i] = $urandom;
    end
    send_triangle(v, 16'($urandom), ($urandom_range(7) == 0));
  endtask

  initial begin
    logic [31:0] vmax[9], vmin[9];
    int sent;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: ray along +z from the origin, tolerance one LSB
    send_flat(-One, -One, 5 * One, 3 * One, 16'h0001, 1);
    send_flat(-One, -One, 8 * One, 3 * One, 16'h0002, 0);
    send_flat(-One, -One, 3 * One, 3 * One, 16'hFFFF, 0);
    send_flat(-One, -One, -2 * One, 3 * One, 16'h0004, 0);
    send_flat(4 * One, -One, 2 * One, 3 * One, 16'h0005, 0);
    send_flat(-One, 4 * One, 2 * One, 3 * One, 16'h0006, 0);
    send_flat(0, 0, 6 * One, One, 16'h0007, 1);
    send_flat(-One, 0, 5 * One, One, 16'h0008, 0);
    send_flat(-One, -One, 2 * One, One, 16'h0009, 0);
    send_flat(-One, -One, 1, 3 * One, 16'h000A, 1);
    send_flat(-One, -One, 2, 3 * One, 16'h000B, 0);
    send_flat(-One, -One, 64'sh7FFF0000, 3 * One, 16'h000C, 1);
    send_triangle('{0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0002_0000},
                  16'h000D, 0);
    send_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 16'h0000, 0);
    vmax = '{default: 32'h7FFF_FFFF};
    vmin = '{default: 32'h8000_0000};
    send_triangle(vmax, 16'h00FF, 0);
    send_triangle(vmin, 16'hFF00, 1);
    send_triangle('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000}, 16'h1234, 0);
    send_flat(64'sh8000_0000, 64'sh8000_0000, One, 64'sh7FFF_FFFF, 16'h5555, 0);
    drain();

    // random phases, each with its own ray; the idle mix changes by thirds
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_ray('{0, 0, 0}, '{0, 0, 32'h0001_0000}, 16'd1);
        1: begin
          write_reg(RegUnused, $urandom);
          set_ray('{rand_signed(1 << 20), rand_signed(1 << 20), rand_signed(1 << 20)},
                  '{rand_signed(1 << 17), rand_signed(1 << 17), rand_signed(1 << 17)},
                  16'd0);
        end
        2: set_ray('{rand_signed(1 << 18), rand_signed(1 << 18), rand_signed(1 << 18)},
                   '{rand_signed(1 << 17), rand_signed(1 << 17), rand_signed(1 << 17)},
                   16'hFFFF);
        3: set_ray('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                   '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 16'($urandom));
        default:
          set_ray('{rand_signed(1 << 20), rand_signed(1 << 20), rand_signed(1 << 20)},
                  '{rand_signed(1 << 17), rand_signed(1 << 17), rand_signed(1 << 17)},
                  16'($urandom_range(255)));
      endcase
      for (int n = 0; n < NumRandom / 6; n++) begin
        if (sent == NumRandom / 3) begin
          tx_idle_pct = 58;
          rx_idle_pct = 18;
        end else if (sent == 2 * NumRandom / 3) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        send_random_triangle();
        sent++;
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
